// ===== src/gf163_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the multiply-by-x step for the GF(2^163) unit.
package gf163_pkg;

  localparam int FLD_BITS  = 163;
  localparam int WORD_BITS = 64;
  localparam int TOP_BITS  = 35;
  localparam int CNT_W     = 8;

  typedef logic [FLD_BITS-1:0] elem_t;

  // Low terms of the reduction polynomial: x^7 + x^6 + x^3 + 1.
  localparam logic [7:0] RED_LOW  = 8'd201;
  localparam elem_t      RED_POLY = elem_t'(RED_LOW);
  localparam elem_t      ONE_ELEM = elem_t'(1);
  // Exponent 2^163 - 2: all ones but bit 0.
  localparam elem_t      INV_EXP  = ~ONE_ELEM;

  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FLD_BITS - 1);
  localparam logic [CNT_W-1:0] POW_STEPS = CNT_W'(FLD_BITS);
  localparam logic [CNT_W-1:0] TRC_STEPS = CNT_W'(FLD_BITS - 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_MUL = 3'd1,
    CMD_SQR = 3'd2,
    CMD_POW = 3'd3,
    CMD_TRC = 3'd4,
    CMD_INV = 3'd5
  } cmd_t;

  // Multiply by x, then reduce.
  function automatic elem_t gf_mulx(input elem_t x);
    elem_t r;
    r = {x[FLD_BITS-2:0], 1'b0};
    if (x[FLD_BITS-1]) begin
      r = r ^ RED_POLY;
    end
    return r;
  endfunction

endpackage

// ===== src/gf2_163_field_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level: GF(2^163) arithmetic unit built round one bit-serial multiplier.
// Add and unused codes are answered from the accepted beat; multiply and square take one pass
// of the shared bit-serial multiplier; power takes a squaring per exponent bit plus a multiply by
// the base per set bit; inverse is a power to 2^163 - 2; trace chains repeated squarings.
// Throughput: one item at a time; the next beat is taken the cycle after the result leaves.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
module gf2_163_field_arithmetic_unit import gf163_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_command,
  input  logic [WORD_BITS-1:0] in_a_lo,
  input  logic [WORD_BITS-1:0] in_a_mid,
  input  logic [TOP_BITS-1:0]  in_a_hi,
  input  logic [WORD_BITS-1:0] in_b_lo,
  input  logic [WORD_BITS-1:0] in_b_mid,
  input  logic [TOP_BITS-1:0]  in_b_hi,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_r_lo,
  output logic [WORD_BITS-1:0] out_r_mid,
  output logic [TOP_BITS-1:0]  out_r_hi
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  // Power: squaring step, or multiply by the base.
  typedef enum logic {
    PH_SQ,
    PH_MB
  } phase_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  elem_t             base_r, base_nxt;   // operand a, kept for power
  elem_t             e_r, e_nxt;         // exponent, scanned from the top bit
  elem_t             s_r, s_nxt;         // running trace sum
  elem_t             res_r, res_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;         // outer steps still to go
  // Shared multiplier: x shifts up with reduction, y shifts down, acc collects.
  elem_t             mx_r, mx_nxt;
  elem_t             my_r, my_nxt;
  elem_t             acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  elem_t             a_in, b_in, pp;

  assign a_in = {in_a_hi, in_a_mid, in_a_lo};
  assign b_in = {in_b_hi, in_b_mid, in_b_lo};
  // Accumulator after this cycle's bit; the full product on the last cycle.
  assign pp   = acc_r ^ (my_r[0] ? mx_r : '0);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_r_lo  = res_r[WORD_BITS-1:0];
  assign out_r_mid = res_r[2*WORD_BITS-1:WORD_BITS];
  assign out_r_hi  = res_r[FLD_BITS-1:2*WORD_BITS];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    base_nxt      = base_r;
    e_nxt         = e_r;
    s_nxt         = s_r;
    res_nxt       = res_r;
    k_nxt         = k_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = cmd_t'(in_command);
          base_nxt = a_in;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          unique case (cmd_t'(in_command))
            CMD_ADD: begin
              res_nxt       = a_in ^ b_in;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_OUT;
            end
            CMD_MUL: begin
              mx_nxt    = a_in;
              my_nxt    = b_in;
              state_nxt = ST_RUN;
            end
            CMD_SQR: begin
              mx_nxt    = a_in;
              my_nxt    = a_in;
              state_nxt = ST_RUN;
            end
            CMD_POW, CMD_INV: begin
              e_nxt     = (cmd_t'(in_command) == CMD_POW) ? b_in : INV_EXP;
              k_nxt     = POW_STEPS;
              phase_nxt = PH_SQ;
              mx_nxt    = ONE_ELEM;
              my_nxt    = ONE_ELEM;
              state_nxt = ST_RUN;
            end
            CMD_TRC: begin
              s_nxt     = a_in;
              k_nxt     = TRC_STEPS;
              mx_nxt    = a_in;
              my_nxt    = a_in;
              state_nxt = ST_RUN;
            end
            default: begin
              res_nxt       = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_OUT;
            end
          endcase
        end
      end

      ST_RUN: begin
        mx_nxt  = gf_mulx(mx_r);
        my_nxt  = my_r >> 1;
        acc_nxt = pp;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          // Product ready in pp: decide the next multiplication or finish.
          acc_nxt = '0;
          cnt_nxt = '0;
          mx_nxt  = pp;
          my_nxt  = pp;
          unique case (cmd_r)
            CMD_POW, CMD_INV: begin
              if (phase_r == PH_SQ && e_r[FLD_BITS-1]) begin
                my_nxt    = base_r;
                phase_nxt = PH_MB;
              end else begin
                phase_nxt = PH_SQ;
                e_nxt     = e_r << 1;
                k_nxt     = k_r - 1'b1;
                if (k_r == CNT_W'(1)) begin
                  res_nxt       = pp;
                  out_valid_nxt = 1'b1;
                  state_nxt     = ST_OUT;
                end
              end
            end
            CMD_TRC: begin
              s_nxt = s_r ^ pp;
              k_nxt = k_r - 1'b1;
              if (k_r == CNT_W'(1)) begin
                res_nxt       = '0;
                res_nxt[0]    = s_r[0] ^ pp[0];
                out_valid_nxt = 1'b1;
                state_nxt     = ST_OUT;
              end
            end
            default: begin
              // plain multiply and square
              res_nxt       = pp;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_OUT;
            end
          endcase
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r <= phase_nxt;
    cmd_r   <= cmd_nxt;
    base_r  <= base_nxt;
    e_r     <= e_nxt;
    s_r     <= s_nxt;
    res_r   <= res_nxt;
    k_r     <= k_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

// ===== src/gf163_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the GF(2^163) unit, bound to the top level.
module gf163_checker import gf163_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_BITS-1:0] out_r_lo,
  input logic [WORD_BITS-1:0] out_r_mid,
  input logic [TOP_BITS-1:0]  out_r_hi
);

  // Reset leaves the unit idle and empty.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("unit not idle after reset");

  // A taken beat closes the input side while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open straight after an accepted beat");

  // No new beat while a result is waiting.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_r_lo) && $stable(out_r_mid) && $stable(out_r_hi)))
    else $error("stalled result changed");

endmodule

bind gf2_163_field_arithmetic_unit gf163_checker u_gf163_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the GF(2^163) arithmetic unit: directed and random operations.
module tb;
  import gf163_pkg::*;

  // Codes 6 and 7 carry no operation; the unit must answer with an all-zero result.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Reduction terms x^7 + x^6 + x^3 + 1, and the inverse exponent 2^163 - 2.
  localparam elem_t POLY_TAIL = elem_t'(201);
  localparam elem_t UNIT_ELEM = elem_t'(1);
  localparam elem_t INV_POWER = ~UNIT_ELEM;
  localparam elem_t ALL_SET   = '1;
  localparam elem_t TOP_TERM  = UNIT_ELEM << (FLD_BITS - 1);

  // Watchdog limit on the whole run, above the slowest correct run.
  localparam int CYCLE_LIMIT = 4_000_000;
  // Receiver hold-off long enough for the unit to back up and stall its input.
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_OPS  = 100;

  typedef struct {
    logic [2:0] command;
    elem_t      a;
    elem_t      b;
  } field_op_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_command = '0;
  logic [WORD_BITS-1:0] in_a_lo = '0;
  logic [WORD_BITS-1:0] in_a_mid = '0;
  logic [TOP_BITS-1:0]  in_a_hi = '0;
  logic [WORD_BITS-1:0] in_b_lo = '0;
  logic [WORD_BITS-1:0] in_b_mid = '0;
  logic [TOP_BITS-1:0]  in_b_hi = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_BITS-1:0] out_r_lo;
  logic [WORD_BITS-1:0] out_r_mid;
  logic [TOP_BITS-1:0]  out_r_hi;

  field_op_t pending_ops[$];    // operations waiting to be offered
  elem_t     field_results[$];  // predicted results, oldest first

  int cycle_count  = 0;
  int ops_issued   = 0;
  int heavy_issued = 0;
  int results_seen = 0;
  int mismatches   = 0;

  // Sender state
  int        tx_gap = 0;
  bit        tx_burst = 1'b0;
  field_op_t next_op;

  // Receiver state
  int    rx_wait = 0;
  int    rx_wait_n;
  int    hold_left = 0;
  int    hold_n;
  bit    rx_burst = 1'b0;
  elem_t due;
  elem_t got;

  gf2_163_field_arithmetic_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_command(in_command),
    .in_a_lo   (in_a_lo),
    .in_a_mid  (in_a_mid),
    .in_a_hi   (in_a_hi),
    .in_b_lo   (in_b_lo),
    .in_b_mid  (in_b_mid),
    .in_b_hi   (in_b_hi),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_r_lo  (out_r_lo),
    .out_r_mid (out_r_mid),
    .out_r_hi  (out_r_hi)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Field arithmetic predictor
  // ---------------------------------------------------------------------------

  // Multiply by x; a carry out of bit 162 folds back in as the low polynomial terms.
  function automatic elem_t times_x(input elem_t x);
    elem_t shifted;
    shifted = x << 1;
    if (x[FLD_BITS-1]) begin
      shifted = shifted ^ POLY_TAIL;
    end
    return shifted;
  endfunction

  // Shift-and-add product, lowest bit of the multiplier first.
  function automatic elem_t field_product(input elem_t x, input elem_t y);
    elem_t acc;
    elem_t run;
    acc = '0;
    run = x;
    for (int i = 0; i < FLD_BITS; i++) begin
      if (y[i]) begin
        acc = acc ^ run;
      end
      run = times_x(run);
    end
    return acc;
  endfunction

  // Square-and-multiply from the top exponent bit down; zero exponent gives one.
  function automatic elem_t field_power(input elem_t base, input elem_t expo);
    elem_t acc;
    acc = UNIT_ELEM;
    for (int i = FLD_BITS - 1; i >= 0; i--) begin
      acc = field_product(acc, acc);
      if (expo[i]) begin
        acc = field_product(acc, base);
      end
    end
    return acc;
  endfunction

  // Sum of the 163 conjugates a^(2^i); only bit 0 survives.
  function automatic logic field_trace(input elem_t x);
    elem_t conj;
    elem_t sum;
    conj = x;
    sum  = x;
    for (int i = 1; i < FLD_BITS; i++) begin
      conj = field_product(conj, conj);
      sum  = sum ^ conj;
    end
    return sum[0];
  endfunction

  function automatic elem_t unit_result(input logic [2:0] cmd, input elem_t a, input elem_t b);
    elem_t r;
    r = '0;
    case (cmd)
      CMD_ADD: r = a ^ b;
      CMD_MUL: r = field_product(a, b);
      CMD_SQR: r = field_product(a, a);
      CMD_POW: r = field_power(a, b);
      CMD_TRC: r[0] = field_trace(a);
      CMD_INV: r = field_power(a, INV_POWER);
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_op(input logic [2:0] cmd, input elem_t a, input elem_t b);
    field_op_t op;
    op.command = cmd;
    op.a       = a;
    op.b       = b;
    pending_ops.push_back(op);
  endfunction

  // Mix of dense, sparse, single-term and extreme operands.
  function automatic elem_t pick_operand();
    elem_t v;
    v = '0;
    for (int i = 0; i < 6; i++) begin
      v = (v << 32) ^ elem_t'($urandom());
    end
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ALL_SET;
      2: v = UNIT_ELEM << $urandom_range(0, FLD_BITS - 1);
      3: v = v & (v >> 7) & (v << 13);
      4: v = v & (ALL_SET << (2 * WORD_BITS));
      default: ;
    endcase
    return v;
  endfunction

  // Power, trace and inverse each chain repeated multiplier passes, so keep them rare.
  function automatic logic [2:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30)      return CMD_ADD;
    else if (roll < 58) return CMD_MUL;
    else if (roll < 84) return CMD_SQR;
    else if (roll < 86) return CMD_SPARE_6;
    else if (roll < 88) return CMD_SPARE_7;
    else if (roll < 90) return CMD_POW;
    else if (roll < 92) return CMD_TRC;
    else if (roll < 94) return CMD_INV;
    else                return CMD_ADD;
  endfunction

  // Sender pause: nothing queued, nothing on the wire, nothing outstanding.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || field_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued operations with random gaps; predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        field_results.push_back(unit_result(in_command, {in_a_hi, in_a_mid, in_a_lo},
                                            {in_b_hi, in_b_mid, in_b_lo}));
        ops_issued++;
        if (in_command == CMD_POW || in_command == CMD_TRC || in_command == CMD_INV) begin
          heavy_issued++;
        end
      end
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        in_command <= next_op.command;
        in_a_lo    <= next_op.a[WORD_BITS-1:0];
        in_a_mid   <= next_op.a[2*WORD_BITS-1:WORD_BITS];
        in_a_hi    <= next_op.a[FLD_BITS-1:2*WORD_BITS];
        in_b_lo    <= next_op.b[WORD_BITS-1:0];
        in_b_mid   <= next_op.b[2*WORD_BITS-1:WORD_BITS];
        in_b_hi    <= next_op.b[FLD_BITS-1:2*WORD_BITS];
        in_valid   <= 1'b1;
        // Occasionally flip between back-to-back bursts and gappy traffic.
        if ($urandom_range(0, 15) == 0) begin
          tx_burst = ~tx_burst;
        end
        tx_gap <= tx_burst ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, long hold-offs, field-by-field check of every result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else begin
      rx_wait_n = rx_wait;
      hold_n    = hold_left;
      if (hold_n > 0) begin
        hold_n--;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got = {out_r_hi, out_r_mid, out_r_lo};
        if (field_results.size() == 0) begin
          $error("result beat with no operation outstanding: %h", got);
          mismatches++;
        end else begin
          due = field_results.pop_front();
          if (out_r_lo !== due[WORD_BITS-1:0]) begin
            $error("r_lo: expected %h, got %h", due[WORD_BITS-1:0], out_r_lo);
            mismatches++;
          end
          if (out_r_mid !== due[2*WORD_BITS-1:WORD_BITS]) begin
            $error("r_mid: expected %h, got %h", due[2*WORD_BITS-1:WORD_BITS], out_r_mid);
            mismatches++;
          end
          if (out_r_hi !== due[FLD_BITS-1:2*WORD_BITS]) begin
            $error("r_hi: expected %h, got %h", due[FLD_BITS-1:2*WORD_BITS], out_r_hi);
            mismatches++;
          end
        end
        // Long hold-offs while cheap operations are still queued behind.
        if (results_seen == 4 || results_seen == 60) begin
          hold_n = LONG_HOLD;
        end
        if ($urandom_range(0, 15) == 0) begin
          rx_burst = ~rx_burst;
        end
        rx_wait_n = rx_burst ? 0 : $urandom_range(0, 14);
      end else if (out_valid && rx_wait_n > 0) begin
        // The drawn wait only runs down while a result is actually on offer.
        rx_wait_n--;
      end
      rx_wait   <= rx_wait_n;
      hold_left <= hold_n;
      out_stall <= (hold_n > 0) || (rx_wait_n > 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, drain, random in two halves, wind-down
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Cheap operations first, so the first long hold-off backs up the input.
    queue_op(CMD_ADD, '0, '0);
    queue_op(CMD_ADD, ALL_SET, '0);
    queue_op(CMD_ADD, ALL_SET, ALL_SET);
    queue_op(CMD_ADD, TOP_TERM, UNIT_ELEM);
    queue_op(CMD_ADD, pick_operand(), pick_operand());
    queue_op(CMD_MUL, ALL_SET, ALL_SET);
    queue_op(CMD_MUL, TOP_TERM, elem_t'(2));   // x^163 wraps through the reduction
    queue_op(CMD_MUL, pick_operand(), UNIT_ELEM);
    queue_op(CMD_MUL, pick_operand(), '0);
    queue_op(CMD_SQR, ALL_SET, pick_operand());
    queue_op(CMD_SQR, TOP_TERM, '0);
    queue_op(CMD_SPARE_6, ALL_SET, ALL_SET);
    queue_op(CMD_SPARE_7, pick_operand(), pick_operand());
    queue_op(CMD_MUL, pick_operand(), pick_operand());
    // Zero exponent yields one, zero base included.
    queue_op(CMD_POW, pick_operand(), '0);
    queue_op(CMD_POW, '0, '0);
    queue_op(CMD_POW, pick_operand(), pick_operand());
    queue_op(CMD_TRC, '0, ALL_SET);
    queue_op(CMD_TRC, UNIT_ELEM, '0);
    queue_op(CMD_TRC, pick_operand(), pick_operand());
    // Inverse of zero comes back as zero.
    queue_op(CMD_INV, '0, ALL_SET);
    queue_op(CMD_INV, UNIT_ELEM, '0);
    queue_op(CMD_INV, pick_operand(), pick_operand());
    wait_drained();

    for (int n = 0; n < RANDOM_OPS / 2; n++) begin
      queue_op(pick_command(), pick_operand(), pick_operand());
    end
    wait_drained();
    for (int n = 0; n < RANDOM_OPS - RANDOM_OPS / 2; n++) begin
      queue_op(pick_command(), pick_operand(), pick_operand());
    end
    wait_drained();

    // Any stray beat after the last expected one shows up here.
    repeat (200) @(posedge clk);
    $display("tb: %0d operations sent, %0d of them power, trace or inverse",
             ops_issued, heavy_issued);
    $display("tb: %0d result beats checked in %0d cycles, %0d mismatches",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== gf2_163_field_arithmetic_unit.f =====
src/gf163_pkg.sv
src/gf2_163_field_arithmetic_unit.sv
src/gf163_checker.sv
tb/tb.sv
